>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen on a rising clock edge out of reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> design/tdpe_pkg.sv
`timescale 1ns / 1ps

package tdpe_pkg;

    localparam logic [3:0] SP_INDEX = 4'd13;
    localparam logic [3:0] PC_INDEX = 4'd15;

    typedef enum logic [2:0] {
        FMT_SHIFT,
        FMT_ADDSUB,
        FMT_IMM8,
        FMT_ALU,
        FMT_HI,
        FMT_ADD_SP_RD,
        FMT_SP_OFS,
        FMT_UNSUP
    } t_fmt;

    typedef enum logic [1:0] {
        SH_LSL,
        SH_LSR,
        SH_ASR,
        SH_ROR
    } t_shift;

    typedef enum logic [1:0] {
        IMM_MOV,
        IMM_CMP,
        IMM_ADD,
        IMM_SUB
    } t_imm_op;

    typedef enum logic [1:0] {
        HI_ADD,
        HI_CMP,
        HI_MOV,
        HI_BX
    } t_hi_op;

    typedef enum logic [3:0] {
        ALU_AND,
        ALU_EOR,
        ALU_LSL,
        ALU_LSR,
        ALU_ASR,
        ALU_ADC,
        ALU_SBC,
        ALU_ROR,
        ALU_TST,
        ALU_NEG,
        ALU_CMP,
        ALU_CMN,
        ALU_ORR,
        ALU_MUL,
        ALU_BIC,
        ALU_MVN
    } t_alu_op;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } t_nzcv;

    typedef struct packed {
        logic [31:0] value;
        logic        carry;
    } t_shift_res;

    typedef struct packed {
        logic [31:0] value;
        t_nzcv       flags;
    } t_add_res;

    typedef struct packed {
        logic [3:0]  idx;
        logic [31:0] val;
        logic        wr;
        t_nzcv       flags;
        logic        ok;
    } t_exec;

    function automatic t_fmt fmt_of(input logic [15:0] ins);
        t_fmt f;
        if (ins[15:13] == 3'b000 && ins[12:11] != 2'b11) begin
            f = FMT_SHIFT;
        end else if (ins[15:11] == 5'b00011) begin
            f = FMT_ADDSUB;
        end else if (ins[15:13] == 3'b001) begin
            f = FMT_IMM8;
        end else if (ins[15:10] == 6'b010000) begin
            f = FMT_ALU;
        end else if (ins[15:10] == 6'b010001) begin
            f = FMT_HI;
        end else if (ins[15:11] == 5'b10101) begin
            f = FMT_ADD_SP_RD;
        end else if (ins[15:8] == 8'hB0) begin
            f = FMT_SP_OFS;
        end else begin
            f = FMT_UNSUP;
        end
        return f;
    endfunction

    function automatic t_nzcv nz_keep(input logic [31:0] v, input t_nzcv old, input logic c);
        t_nzcv f;
        f.n = v[31];
        f.z = (v == 32'd0);
        f.c = c;
        f.v = old.v;
        return f;
    endfunction

    function automatic t_add_res add_nzcv(input logic [31:0] a, input logic [31:0] b,
                                          input logic cin);
        t_add_res   res;
        logic [32:0] sum;
        sum         = {1'b0, a} + {1'b0, b} + {32'd0, cin};
        res.value   = sum[31:0];
        res.flags.n = sum[31];
        res.flags.z = (sum[31:0] == 32'd0);
        res.flags.c = sum[32];
        res.flags.v = ~(a[31] ^ b[31]) & (a[31] ^ sum[31]);
        return res;
    endfunction

    function automatic t_shift_res shift_op(input t_shift kind, input logic [31:0] v,
                                            input logic [7:0] amt, input logic cin);
        t_shift_res res;
        logic [32:0] tmp;
        logic [63:0] rot;
        res.value = v;
        res.carry = cin;
        tmp       = '0;
        rot       = '0;
        if (amt != 8'd0) begin
            case (kind)
                SH_LSL: begin
                    if (amt < 8'd32) begin
                        tmp       = {1'b0, v} << amt[4:0];
                        res.value = tmp[31:0];
                        res.carry = tmp[32];
                    end else begin
                        res.value = '0;
                        res.carry = (amt == 8'd32) ? v[0] : 1'b0;
                    end
                end
                SH_LSR: begin
                    if (amt < 8'd32) begin
                        tmp       = {v, 1'b0} >> amt[4:0];
                        res.value = tmp[32:1];
                        res.carry = tmp[0];
                    end else begin
                        res.value = '0;
                        res.carry = (amt == 8'd32) ? v[31] : 1'b0;
                    end
                end
                SH_ASR: begin
                    if (amt < 8'd32) begin
                        tmp       = $unsigned($signed({v, 1'b0}) >>> amt[4:0]);
                        res.value = tmp[32:1];
                        res.carry = tmp[0];
                    end else begin
                        res.value = {32{v[31]}};
                        res.carry = v[31];
                    end
                end
                default: begin
                    rot       = {v, v} >> amt[4:0];
                    res.value = rot[31:0];
                    res.carry = rot[31];
                end
            endcase
        end
        return res;
    endfunction

endpackage

>>> design/thumb_data_processing_execute.sv
// channel   dir  valid    stall    payload
// request   in   i_valid  o_stall  i_instruction
// result    out  o_valid  i_stall  o_dest_index o_dest_value o_dest_written
//                                  o_flag_neg o_flag_zero o_flag_carry
//                                  o_flag_overflow o_status
//
// One request per cycle while o_stall is low; each result is registered at the end of stage two.
// Stage one reads two register operands from the register memory (write result forwarded),
// stage two executes and writes the register file and flags.
// Synchronous active-low reset clears flags, register valid bits and both stage valids.
// A stalled result holds the execute stage; o_stall rises only when both stages are full.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module thumb_data_processing_execute (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_instruction,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_dest_index,
    output logic [31:0] o_dest_value,
    output logic        o_dest_written,
    output logic        o_flag_neg,
    output logic        o_flag_zero,
    output logic        o_flag_carry,
    output logic        o_flag_overflow,
    output logic        o_status
);
    import tdpe_pkg::*;

    logic [31:0] r_regs [16];
    logic [15:0] r_reg_valid;
    t_nzcv       r_flags;

    logic        r_x_valid;
    logic [15:0] r_ins;
    t_fmt        r_fmt;
    logic [31:0] r_a;
    logic [31:0] r_b;

    logic        r_o_valid;
    logic [3:0]  r_dest_index;
    logic [31:0] r_dest_value;
    logic        r_dest_written;
    t_nzcv       r_out_flags;
    logic        r_status;

    logic        acc;
    logic        adv;
    t_fmt        id_fmt;
    logic [3:0]  rd_addr_a;
    logic [3:0]  rd_addr_b;
    t_exec       ex;

    assign adv     = r_x_valid && (!r_o_valid || !i_stall);
    assign o_stall = r_x_valid && !adv;
    assign acc     = i_valid && !o_stall;

    // operand select
    always_comb begin
        id_fmt    = fmt_of(i_instruction);
        rd_addr_a = '0;
        rd_addr_b = '0;
        unique case (id_fmt)
            FMT_SHIFT: begin
                rd_addr_a = {1'b0, i_instruction[5:3]};
            end
            FMT_ADDSUB: begin
                rd_addr_a = {1'b0, i_instruction[5:3]};
                rd_addr_b = {1'b0, i_instruction[8:6]};
            end
            FMT_IMM8: begin
                rd_addr_a = {1'b0, i_instruction[10:8]};
            end
            FMT_ALU: begin
                rd_addr_a = {1'b0, i_instruction[2:0]};
                rd_addr_b = {1'b0, i_instruction[5:3]};
            end
            FMT_HI: begin
                rd_addr_a = {i_instruction[7], i_instruction[2:0]};
                rd_addr_b = {i_instruction[6], i_instruction[5:3]};
            end
            FMT_ADD_SP_RD, FMT_SP_OFS: begin
                rd_addr_a = SP_INDEX;
            end
            default: begin
                rd_addr_a = '0;
            end
        endcase
    end

    // execute
    always_comb begin
        t_shift_res  sh;
        t_add_res    ad;
        logic [31:0] bop;
        logic [31:0] off;
        logic [7:0]  amt;
        logic [3:0]  hd;
        sh       = '0;
        ad       = '0;
        bop      = '0;
        off      = '0;
        amt      = '0;
        hd       = {r_ins[7], r_ins[2:0]};
        ex.idx   = '0;
        ex.val   = '0;
        ex.wr    = 1'b0;
        ex.flags = r_flags;
        ex.ok    = 1'b1;
        unique case (r_fmt)
            FMT_SHIFT: begin
                amt = {3'b000, r_ins[10:6]};
                if (t_shift'(r_ins[12:11]) != SH_LSL && r_ins[10:6] == 5'd0) begin
                    amt = 8'd32;
                end
                sh       = shift_op(t_shift'(r_ins[12:11]), r_a, amt, r_flags.c);
                ex.val   = sh.value;
                ex.flags = nz_keep(sh.value, r_flags, sh.carry);
                ex.idx   = {1'b0, r_ins[2:0]};
                ex.wr    = 1'b1;
            end
            FMT_ADDSUB: begin
                bop = r_ins[10] ? {29'd0, r_ins[8:6]} : r_b;
                if (r_ins[9]) begin
                    ad = add_nzcv(r_a, ~bop, 1'b1);
                end else begin
                    ad = add_nzcv(r_a, bop, 1'b0);
                end
                ex.val   = ad.value;
                ex.flags = ad.flags;
                ex.idx   = {1'b0, r_ins[2:0]};
                ex.wr    = 1'b1;
            end
            FMT_IMM8: begin
                bop    = {24'd0, r_ins[7:0]};
                ex.idx = {1'b0, r_ins[10:8]};
                ex.wr  = 1'b1;
                case (t_imm_op'(r_ins[12:11]))
                    IMM_MOV: begin
                        ex.val   = bop;
                        ex.flags = nz_keep(bop, r_flags, r_flags.c);
                    end
                    IMM_CMP: begin
                        ad       = add_nzcv(r_a, ~bop, 1'b1);
                        ex.flags = ad.flags;
                        ex.idx   = '0;
                        ex.wr    = 1'b0;
                    end
                    IMM_ADD: begin
                        ad       = add_nzcv(r_a, bop, 1'b0);
                        ex.val   = ad.value;
                        ex.flags = ad.flags;
                    end
                    default: begin
                        ad       = add_nzcv(r_a, ~bop, 1'b1);
                        ex.val   = ad.value;
                        ex.flags = ad.flags;
                    end
                endcase
            end
            FMT_ALU: begin
                ex.idx = {1'b0, r_ins[2:0]};
                ex.wr  = 1'b1;
                unique case (t_alu_op'(r_ins[9:6]))
                    ALU_AND: begin
                        ex.val   = r_a & r_b;
                        ex.flags = nz_keep(ex.val, r_flags, r_flags.c);
                    end
                    ALU_EOR: begin
                        ex.val   = r_a ^ r_b;
                        ex.flags = nz_keep(ex.val, r_flags, r_flags.c);
                    end
                    ALU_LSL: begin
                        sh       = shift_op(SH_LSL, r_a, r_b[7:0], r_flags.c);
                        ex.val   = sh.value;
                        ex.flags = nz_keep(sh.value, r_flags, sh.carry);
                    end
                    ALU_LSR: begin
                        sh       = shift_op(SH_LSR, r_a, r_b[7:0], r_flags.c);
                        ex.val   = sh.value;
                        ex.flags = nz_keep(sh.value, r_flags, sh.carry);
                    end
                    ALU_ASR: begin
                        sh       = shift_op(SH_ASR, r_a, r_b[7:0], r_flags.c);
                        ex.val   = sh.value;
                        ex.flags = nz_keep(sh.value, r_flags, sh.carry);
                    end
                    ALU_ADC: begin
                        ad       = add_nzcv(r_a, r_b, r_flags.c);
                        ex.val   = ad.value;
                        ex.flags = ad.flags;
                    end
                    ALU_SBC: begin
                        ad       = add_nzcv(r_a, ~r_b, r_flags.c);
                        ex.val   = ad.value;
                        ex.flags = ad.flags;
                    end
                    ALU_ROR: begin
                        sh       = shift_op(SH_ROR, r_a, r_b[7:0], r_flags.c);
                        ex.val   = sh.value;
                        ex.flags = nz_keep(sh.value, r_flags, sh.carry);
                    end
                    ALU_TST: begin
                        ex.flags = nz_keep(r_a & r_b, r_flags, r_flags.c);
                        ex.idx   = '0;
                        ex.wr    = 1'b0;
                    end
                    ALU_NEG: begin
                        ad       = add_nzcv(32'd0, ~r_b, 1'b1);
                        ex.val   = ad.value;
                        ex.flags = ad.flags;
                    end
                    ALU_CMP: begin
                        ad       = add_nzcv(r_a, ~r_b, 1'b1);
                        ex.flags = ad.flags;
                        ex.idx   = '0;
                        ex.wr    = 1'b0;
                    end
                    ALU_CMN: begin
                        ad       = add_nzcv(r_a, r_b, 1'b0);
                        ex.flags = ad.flags;
                        ex.idx   = '0;
                        ex.wr    = 1'b0;
                    end
                    ALU_ORR: begin
                        ex.val   = r_a | r_b;
                        ex.flags = nz_keep(ex.val, r_flags, r_flags.c);
                    end
                    ALU_MUL: begin
                        ex.val   = r_a * r_b;
                        ex.flags = nz_keep(ex.val, r_flags, r_flags.c);
                    end
                    ALU_BIC: begin
                        ex.val   = r_a & ~r_b;
                        ex.flags = nz_keep(ex.val, r_flags, r_flags.c);
                    end
                    default: begin
                        ex.val   = ~r_b;
                        ex.flags = nz_keep(ex.val, r_flags, r_flags.c);
                    end
                endcase
            end
            FMT_HI: begin
                if (t_hi_op'(r_ins[9:8]) == HI_BX
                    || (t_hi_op'(r_ins[9:8]) != HI_CMP && hd == PC_INDEX)) begin
                    ex.ok = 1'b0;
                end else if (t_hi_op'(r_ins[9:8]) == HI_CMP) begin
                    ad       = add_nzcv(r_a, ~r_b, 1'b1);
                    ex.flags = ad.flags;
                end else begin
                    ex.val = (t_hi_op'(r_ins[9:8]) == HI_ADD) ? r_a + r_b : r_b;
                    ex.idx = hd;
                    ex.wr  = 1'b1;
                end
            end
            FMT_ADD_SP_RD: begin
                ex.val = r_a + {22'd0, r_ins[7:0], 2'b00};
                ex.idx = {1'b0, r_ins[10:8]};
                ex.wr  = 1'b1;
            end
            FMT_SP_OFS: begin
                off    = {23'd0, r_ins[6:0], 2'b00};
                ex.val = r_ins[7] ? r_a - off : r_a + off;
                ex.idx = SP_INDEX;
                ex.wr  = 1'b1;
            end
            default: begin
                ex.ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_valid   <= 1'b0;
            r_o_valid   <= 1'b0;
            r_reg_valid <= '0;
            r_flags     <= '0;
        end else begin
            if (acc) begin
                r_x_valid <= 1'b1;
            end else if (adv) begin
                r_x_valid <= 1'b0;
            end
            if (adv) begin
                r_o_valid <= 1'b1;
                r_flags   <= ex.flags;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            if (adv && ex.wr) begin
                r_reg_valid[ex.idx] <= 1'b1;
            end
        end
    end

    // register memory, operand reads with forwarding of the retiring write
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_ins <= i_instruction;
            r_fmt <= id_fmt;
            if (adv && ex.wr && ex.idx == rd_addr_a) begin
                r_a <= ex.val;
            end else if (r_reg_valid[rd_addr_a]) begin
                r_a <= r_regs[rd_addr_a];
            end else begin
                r_a <= '0;
            end
            if (adv && ex.wr && ex.idx == rd_addr_b) begin
                r_b <= ex.val;
            end else if (r_reg_valid[rd_addr_b]) begin
                r_b <= r_regs[rd_addr_b];
            end else begin
                r_b <= '0;
            end
        end
        if (adv && ex.wr) begin
            r_regs[ex.idx] <= ex.val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dest_index   <= ex.idx;
            r_dest_value   <= ex.val;
            r_dest_written <= ex.wr;
            r_out_flags    <= ex.flags;
            r_status       <= !ex.ok;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_dest_index    = r_dest_index;
    assign o_dest_value    = r_dest_value;
    assign o_dest_written  = r_dest_written;
    assign o_flag_neg      = r_out_flags.n;
    assign o_flag_zero     = r_out_flags.z;
    assign o_flag_carry    = r_out_flags.c;
    assign o_flag_overflow = r_out_flags.v;
    assign o_status        = r_status;

    `ASSERT_CLK(a_flags_hold, i_clk, i_rst_n,
        !adv |=> $stable(r_flags), "flags moved without retire")
    `ASSERT_CLK(a_exec_hold, i_clk, i_rst_n,
        (r_x_valid && !adv) |=> (r_x_valid && $stable(r_ins)), "execute stage lost item")
    `ASSERT_CLK(a_retire_out, i_clk, i_rst_n,
        adv |=> (o_valid && o_flag_zero == $past(ex.flags.z)), "retire not shown")
    `ASSERT_NEVER(a_unsup_write, i_clk, i_rst_n,
        adv && !ex.ok && ex.wr, "unsupported word writes register")

endmodule

>>> verif/tb_thumb_data_processing_execute.sv
`timescale 1ns / 1ps

module tb_thumb_data_processing_execute;
    import tdpe_pkg::*;

    typedef struct packed {
        logic [3:0]  dest_index;
        logic [31:0] dest_value;
        logic        dest_written;
        t_nzcv       flags;
        logic        status;
    } t_writeback;

    typedef struct packed {
        logic [31:0] value;
        logic        carry;
    } t_shifted;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [15:0] i_instruction = 16'd0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [3:0]  o_dest_index;
    logic [31:0] o_dest_value;
    logic        o_dest_written;
    logic        o_flag_neg;
    logic        o_flag_zero;
    logic        o_flag_carry;
    logic        o_flag_overflow;
    logic        o_status;

    // architectural state tracked alongside the block
    logic [31:0] arch_regs [16];
    t_nzcv       arch_flags;

    t_writeback  expected_writebacks [$];
    t_writeback  oldest_writeback;

    int          error_count = 0;
    int          issued_count = 0;
    int          checked_count = 0;
    int          unsupported_count = 0;

    logic        sender_idle_en = 1'b1;
    logic        receiver_idle_en = 1'b1;
    int          receiver_hold_cycles = 0;
    int          receiver_burst_left = 0;

    thumb_data_processing_execute u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_instruction   (i_instruction),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_dest_index    (o_dest_index),
        .o_dest_value    (o_dest_value),
        .o_dest_written  (o_dest_written),
        .o_flag_neg      (o_flag_neg),
        .o_flag_zero     (o_flag_zero),
        .o_flag_carry    (o_flag_carry),
        .o_flag_overflow (o_flag_overflow),
        .o_status        (o_status)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------

    function automatic logic [31:0] add_set_flags(input logic [31:0] a, input logic [31:0] b,
                                                  input logic cin);
        logic [32:0] wide;
        wide         = {1'b0, a} + {1'b0, b} + {32'd0, cin};
        arch_flags.n = wide[31];
        arch_flags.z = (wide[31:0] == 32'd0);
        arch_flags.c = wide[32];
        arch_flags.v = (a[31] == b[31]) && (wide[31] != a[31]);
        return wide[31:0];
    endfunction

    function automatic void set_logic_flags(input logic [31:0] v);
        arch_flags.n = v[31];
        arch_flags.z = (v == 32'd0);
    endfunction

    function automatic t_shifted barrel_shift(input t_shift kind, input logic [31:0] v,
                                              input logic [7:0] amt, input logic cin);
        t_shifted r;
        int       n;
        int       s;
        n       = amt;
        r.value = v;
        r.carry = cin;
        if (n != 0) begin
            case (kind)
                SH_LSL: begin
                    if (n < 32) begin
                        r.carry = v[32 - n];
                        r.value = v << n;
                    end else begin
                        r.carry = (n == 32) ? v[0] : 1'b0;
                        r.value = 32'd0;
                    end
                end
                SH_LSR: begin
                    if (n < 32) begin
                        r.carry = v[n - 1];
                        r.value = v >> n;
                    end else begin
                        r.carry = (n == 32) ? v[31] : 1'b0;
                        r.value = 32'd0;
                    end
                end
                SH_ASR: begin
                    if (n < 32) begin
                        r.carry = v[n - 1];
                        r.value = $signed(v) >>> n;
                    end else begin
                        r.carry = v[31];
                        r.value = {32{v[31]}};
                    end
                end
                default: begin
                    s = n % 32;
                    if (s != 0) begin
                        r.value = (v >> s) | (v << (32 - s));
                    end
                    r.carry = r.value[31];
                end
            endcase
        end
        return r;
    endfunction

    function automatic t_writeback execute_thumb(input logic [15:0] ins);
        t_writeback  wb;
        t_shifted    sh;
        logic [31:0] vd;
        logic [31:0] vs;
        logic [31:0] off;
        logic [7:0]  amt;
        logic [3:0]  hs;
        logic [3:0]  hd;
        t_hi_op      hop;
        wb = '0;
        if (ins[15:13] == 3'b000 && ins[12:11] != 2'b11) begin
            amt = {3'd0, ins[10:6]};
            if (t_shift'(ins[12:11]) != SH_LSL && amt == 8'd0) begin
                amt = 8'd32;
            end
            sh = barrel_shift(t_shift'(ins[12:11]), arch_regs[{1'b0, ins[5:3]}], amt,
                              arch_flags.c);
            set_logic_flags(sh.value);
            arch_flags.c    = sh.carry;
            wb.dest_value   = sh.value;
            wb.dest_index   = {1'b0, ins[2:0]};
            wb.dest_written = 1'b1;
        end else if (ins[15:11] == 5'b00011) begin
            vs = ins[10] ? {29'd0, ins[8:6]} : arch_regs[{1'b0, ins[8:6]}];
            vd = arch_regs[{1'b0, ins[5:3]}];
            wb.dest_value   = ins[9] ? add_set_flags(vd, ~vs, 1'b1) : add_set_flags(vd, vs, 1'b0);
            wb.dest_index   = {1'b0, ins[2:0]};
            wb.dest_written = 1'b1;
        end else if (ins[15:13] == 3'b001) begin
            vd = arch_regs[{1'b0, ins[10:8]}];
            vs = {24'd0, ins[7:0]};
            wb.dest_index   = {1'b0, ins[10:8]};
            wb.dest_written = 1'b1;
            case (t_imm_op'(ins[12:11]))
                IMM_MOV: begin
                    wb.dest_value = vs;
                    set_logic_flags(vs);
                end
                IMM_CMP: begin
                    void'(add_set_flags(vd, ~vs, 1'b1));
                    wb.dest_written = 1'b0;
                end
                IMM_ADD: wb.dest_value = add_set_flags(vd, vs, 1'b0);
                default: wb.dest_value = add_set_flags(vd, ~vs, 1'b1);
            endcase
        end else if (ins[15:10] == 6'b010000) begin
            vd = arch_regs[{1'b0, ins[2:0]}];
            vs = arch_regs[{1'b0, ins[5:3]}];
            wb.dest_index   = {1'b0, ins[2:0]};
            wb.dest_written = 1'b1;
            case (t_alu_op'(ins[9:6]))
                ALU_AND: begin
                    wb.dest_value = vd & vs;
                    set_logic_flags(wb.dest_value);
                end
                ALU_EOR: begin
                    wb.dest_value = vd ^ vs;
                    set_logic_flags(wb.dest_value);
                end
                ALU_LSL, ALU_LSR, ALU_ASR, ALU_ROR: begin
                    case (t_alu_op'(ins[9:6]))
                        ALU_LSL: sh = barrel_shift(SH_LSL, vd, vs[7:0], arch_flags.c);
                        ALU_LSR: sh = barrel_shift(SH_LSR, vd, vs[7:0], arch_flags.c);
                        ALU_ASR: sh = barrel_shift(SH_ASR, vd, vs[7:0], arch_flags.c);
                        default: sh = barrel_shift(SH_ROR, vd, vs[7:0], arch_flags.c);
                    endcase
                    wb.dest_value = sh.value;
                    set_logic_flags(sh.value);
                    arch_flags.c = sh.carry;
                end
                ALU_ADC: wb.dest_value = add_set_flags(vd, vs, arch_flags.c);
                ALU_SBC: wb.dest_value = add_set_flags(vd, ~vs, arch_flags.c);
                ALU_TST: begin
                    set_logic_flags(vd & vs);
                    wb.dest_written = 1'b0;
                end
                ALU_NEG: wb.dest_value = add_set_flags(32'd0, ~vs, 1'b1);
                ALU_CMP: begin
                    void'(add_set_flags(vd, ~vs, 1'b1));
                    wb.dest_written = 1'b0;
                end
                ALU_CMN: begin
                    void'(add_set_flags(vd, vs, 1'b0));
                    wb.dest_written = 1'b0;
                end
                ALU_ORR: begin
                    wb.dest_value = vd | vs;
                    set_logic_flags(wb.dest_value);
                end
                ALU_MUL: begin
                    wb.dest_value = vd * vs;
                    set_logic_flags(wb.dest_value);
                end
                ALU_BIC: begin
                    wb.dest_value = vd & ~vs;
                    set_logic_flags(wb.dest_value);
                end
                default: begin
                    wb.dest_value = ~vs;
                    set_logic_flags(wb.dest_value);
                end
            endcase
        end else if (ins[15:10] == 6'b010001) begin
            hop = t_hi_op'(ins[9:8]);
            hs  = {ins[6], ins[5:3]};
            hd  = {ins[7], ins[2:0]};
            if (hop == HI_BX || (hop != HI_CMP && hd == PC_INDEX)) begin
                wb.status = 1'b1;
            end else if (hop == HI_CMP) begin
                void'(add_set_flags(arch_regs[hd], ~arch_regs[hs], 1'b1));
            end else begin
                wb.dest_value   = (hop == HI_ADD) ? arch_regs[hd] + arch_regs[hs] : arch_regs[hs];
                wb.dest_index   = hd;
                wb.dest_written = 1'b1;
            end
        end else if (ins[15:11] == 5'b10101) begin
            wb.dest_value   = arch_regs[SP_INDEX] + {22'd0, ins[7:0], 2'b00};
            wb.dest_index   = {1'b0, ins[10:8]};
            wb.dest_written = 1'b1;
        end else if (ins[15:8] == 8'hB0) begin
            off             = {23'd0, ins[6:0], 2'b00};
            wb.dest_value   = ins[7] ? arch_regs[SP_INDEX] - off : arch_regs[SP_INDEX] + off;
            wb.dest_index   = SP_INDEX;
            wb.dest_written = 1'b1;
        end else begin
            wb.status = 1'b1;
        end
        if (wb.dest_written) begin
            arch_regs[wb.dest_index] = wb.dest_value;
        end else begin
            wb.dest_index = 4'd0;
            wb.dest_value = 32'd0;
        end
        wb.flags = arch_flags;
        return wb;
    endfunction

    // ---------------- encoders ----------------

    function automatic logic [15:0] enc_shift(input t_shift kind, input logic [4:0] imm,
                                              input logic [2:0] rs, input logic [2:0] rd);
        return {3'b000, kind, imm, rs, rd};
    endfunction

    function automatic logic [15:0] enc_addsub(input logic imm, input logic sub,
                                               input logic [2:0] rn, input logic [2:0] rs,
                                               input logic [2:0] rd);
        return {5'b00011, imm, sub, rn, rs, rd};
    endfunction

    function automatic logic [15:0] enc_imm8(input t_imm_op op, input logic [2:0] rd,
                                             input logic [7:0] imm);
        return {3'b001, op, rd, imm};
    endfunction

    function automatic logic [15:0] enc_alu(input t_alu_op op, input logic [2:0] rs,
                                            input logic [2:0] rd);
        return {6'b010000, op, rs, rd};
    endfunction

    function automatic logic [15:0] enc_hi(input t_hi_op op, input logic [3:0] rs,
                                           input logic [3:0] rd);
        return {6'b010001, op, rd[3], rs[3], rs[2:0], rd[2:0]};
    endfunction

    function automatic logic [15:0] random_instruction();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
            return 16'($urandom);
        end else if (sel < 20) begin
            return enc_shift(t_shift'($urandom_range(0, 2)), 5'($urandom), 3'($urandom),
                             3'($urandom));
        end else if (sel < 30) begin
            return enc_addsub(1'($urandom), 1'($urandom), 3'($urandom), 3'($urandom),
                              3'($urandom));
        end else if (sel < 45) begin
            return enc_imm8(t_imm_op'($urandom_range(0, 3)), 3'($urandom), 8'($urandom));
        end else if (sel < 75) begin
            return enc_alu(t_alu_op'($urandom_range(0, 15)), 3'($urandom), 3'($urandom));
        end else if (sel < 85) begin
            return enc_hi(t_hi_op'($urandom_range(0, 3)), 4'($urandom), 4'($urandom));
        end else if (sel < 90) begin
            return {5'b10101, 11'($urandom)};
        end else if (sel < 95) begin
            return {8'hB0, 8'($urandom)};
        end
        return 16'($urandom_range(16'h4800, 16'hFFFF));
    endfunction

    // ---------------- request side ----------------

    task automatic send_instruction(input logic [15:0] ins);
        int gap;
        gap = 0;
        if (sender_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
        end
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_instruction <= ins;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        expected_writebacks.push_back(execute_thumb(ins));
        issued_count++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_writebacks.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // ---------------- result side ----------------

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (receiver_hold_cycles > 0) begin
            i_stall <= 1'b1;
            receiver_hold_cycles--;
        end else if (receiver_burst_left > 0) begin
            i_stall <= 1'b1;
            receiver_burst_left--;
        end else if (receiver_idle_en && $urandom_range(0, 5) == 0) begin
            i_stall             <= 1'b1;
            receiver_burst_left = $urandom_range(0, 9);
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_val, act_val);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_writebacks.size() == 0) begin
                $display("%0t: unexpected result, expected none actual index %h value %h",
                         $time, o_dest_index, o_dest_value);
                error_count++;
            end else begin
                oldest_writeback = expected_writebacks.pop_front();
                check_field("dest_index", 32'(oldest_writeback.dest_index), 32'(o_dest_index));
                check_field("dest_value", oldest_writeback.dest_value, o_dest_value);
                check_field("dest_written", 32'(oldest_writeback.dest_written),
                            32'(o_dest_written));
                check_field("flag_neg", 32'(oldest_writeback.flags.n), 32'(o_flag_neg));
                check_field("flag_zero", 32'(oldest_writeback.flags.z), 32'(o_flag_zero));
                check_field("flag_carry", 32'(oldest_writeback.flags.c), 32'(o_flag_carry));
                check_field("flag_overflow", 32'(oldest_writeback.flags.v),
                            32'(o_flag_overflow));
                check_field("status", 32'(oldest_writeback.status), 32'(o_status));
                if (oldest_writeback.status) begin
                    unsupported_count++;
                end
                checked_count++;
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_formats();
        send_instruction(enc_imm8(IMM_MOV, 3'd0, 8'hFF));
        send_instruction(enc_imm8(IMM_MOV, 3'd1, 8'h00));
        send_instruction(enc_alu(ALU_MVN, 3'd1, 3'd2));
        send_instruction(enc_addsub(1'b1, 1'b0, 3'd1, 3'd2, 3'd3));
        send_instruction(enc_shift(SH_LSL, 5'd0, 3'd2, 3'd6));        // keeps carry
        send_instruction(enc_shift(SH_LSR, 5'd1, 3'd2, 3'd5));
        send_instruction(enc_addsub(1'b1, 1'b0, 3'd1, 3'd5, 3'd5));   // signed overflow
        send_instruction(enc_addsub(1'b0, 1'b1, 3'd0, 3'd1, 3'd4));
        send_instruction(enc_shift(SH_LSR, 5'd0, 3'd2, 3'd6));        // shift by 32
        send_instruction(enc_shift(SH_ASR, 5'd0, 3'd5, 3'd7));
        send_instruction(enc_imm8(IMM_ADD, 3'd0, 8'hFF));
        send_instruction(enc_imm8(IMM_SUB, 3'd0, 8'hFF));
        send_instruction(enc_imm8(IMM_CMP, 3'd1, 8'h00));
        send_instruction(enc_hi(HI_MOV, 4'd5, SP_INDEX));
        send_instruction(enc_hi(HI_ADD, 4'd5, 4'd8));
        send_instruction(enc_hi(HI_CMP, 4'd8, PC_INDEX));
        send_instruction(enc_hi(HI_ADD, 4'd1, 4'd0));                 // both H bits clear
        send_instruction({5'b10101, 3'd6, 8'hFF});
        send_instruction({8'hB0, 1'b1, 7'h7F});
        send_instruction({8'hB0, 1'b0, 7'h7F});
        drain_results();
    endtask

    task automatic test_alu_ops();
        int k;
        for (k = 0; k < 16; k++) begin
            send_instruction(enc_alu(t_alu_op'(k), 3'(k + 3), 3'(k)));
        end
        send_instruction(enc_imm8(IMM_MOV, 3'd4, 8'd33));
        send_instruction(enc_alu(ALU_LSL, 3'd4, 3'd2));
        send_instruction(enc_imm8(IMM_MOV, 3'd4, 8'd64));
        send_instruction(enc_alu(ALU_ROR, 3'd4, 3'd7));
        drain_results();
    endtask

    task automatic test_unsupported();
        logic [15:0] words [$];
        // loads/stores, pc-relative, add pc, push, ldm/stm, branches, swi, bl, bx
        words = '{16'h4800, 16'h5000, 16'h6000, 16'h8000, 16'h9000, 16'hA000, 16'hB400,
                  16'hC000, 16'hD000, 16'hDE00, 16'hDF00, 16'hE000, 16'hF000, 16'hF800,
                  16'h4700, 16'hB100, 16'hFFFF};
        foreach (words[k]) begin
            send_instruction(words[k]);
        end
        send_instruction(enc_hi(HI_ADD, 4'd1, PC_INDEX));
        send_instruction(enc_hi(HI_MOV, 4'd2, PC_INDEX));
        drain_results();
    endtask

    task automatic run_random_mix(input int count, input logic vary_idle);
        int         k;
        logic [2:0] rx;
        logic [7:0] amt;
        t_alu_op    sop;
        for (k = 0; k < count; k++) begin
            if (vary_idle && k % 64 == 0) begin
                sender_idle_en   = ($urandom_range(0, 2) != 0);
                receiver_idle_en = ($urandom_range(0, 2) != 0);
            end
            if ($urandom_range(0, 9) == 0) begin
                // load a boundary shift amount, then shift by it
                rx = 3'($urandom);
                case ($urandom_range(0, 7))
                    0: amt = 8'd0;
                    1: amt = 8'd1;
                    2: amt = 8'd31;
                    3: amt = 8'd32;
                    4: amt = 8'd33;
                    5: amt = 8'd64;
                    6: amt = 8'd96;
                    default: amt = 8'($urandom);
                endcase
                case ($urandom_range(0, 3))
                    0: sop = ALU_LSL;
                    1: sop = ALU_LSR;
                    2: sop = ALU_ASR;
                    default: sop = ALU_ROR;
                endcase
                send_instruction(enc_imm8(IMM_MOV, rx, amt));
                send_instruction(enc_alu(sop, rx, 3'($urandom)));
                k++;
            end else begin
                send_instruction(random_instruction());
            end
        end
        drain_results();
    endtask

    task automatic test_backpressure();
        int k;
        sender_idle_en       = 1'b0;
        receiver_hold_cycles = 60;
        for (k = 0; k < 40; k++) begin
            send_instruction(random_instruction());
        end
        drain_results();
    endtask

    task automatic test_no_idle();
        sender_idle_en       = 1'b0;
        receiver_idle_en     = 1'b0;
        receiver_burst_left  = 0;
        run_random_mix(200, 1'b0);
    endtask

    initial begin
        foreach (arch_regs[k]) begin
            arch_regs[k] = 32'd0;
        end
        arch_flags = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_formats();
        test_alu_ops();
        test_unsupported();
        run_random_mix(400, 1'b1);
        test_backpressure();
        run_random_mix(380, 1'b1);
        test_no_idle();
        $display("Run covered all Thumb ALU formats, register shift corner amounts,");
        $display("unsupported words and a long result hold: %0d issued, %0d checked,",
                 issued_count, checked_count);
        $display("%0d unsupported", unsupported_count);
        if (error_count == 0 && expected_writebacks.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
